// File: design/hms_pkg.sv
// Shared types and constants for the h:m:s time text parser.
// Used by hms_front, hms_queue, hms_back and the top level.
package hms_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam int CH_W    = 8;
  localparam int FIELD_W = 31;
  localparam int TOTAL_W = 32;

  // character classes carried from front to back
  localparam logic [1:0] CLS_BLANK = 2'd0;
  localparam logic [1:0] CLS_DIGIT = 2'd1;
  localparam logic [1:0] CLS_COLON = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  localparam logic [CH_W-1:0] CHR_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CHR_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CHR_COLON = 8'h3A;
  localparam logic [CH_W-1:0] CHR_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CHR_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CHR_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CHR_LF    = 8'h0A;

  typedef struct packed {
    logic       last;
    logic [1:0] kind;
    logic [3:0] digit;
  } item_t;

endpackage

// File: design/hms_front.sv
// Front end: classifies each incoming character into a queue entry.
// Depends on hms_pkg for the class codes and the item_t entry.
module hms_front (
  input  logic [hms_pkg::CH_W-1:0] ch,
  input  logic                     last,
  output hms_pkg::item_t           item
);

  logic [hms_pkg::CH_W-1:0] ofs;

  assign ofs = ch - hms_pkg::CHR_ZERO;

  always_comb begin
    item.last  = last;
    item.digit = ofs[3:0];
    if (ch >= hms_pkg::CHR_ZERO && ch <= hms_pkg::CHR_NINE) begin
      item.kind = hms_pkg::CLS_DIGIT;
    end else if (ch == hms_pkg::CHR_COLON) begin
      item.kind = hms_pkg::CLS_COLON;
    end else if (ch == hms_pkg::CHR_SPACE || ch == hms_pkg::CHR_TAB ||
                 ch == hms_pkg::CHR_CR || ch == hms_pkg::CHR_LF) begin
      item.kind = hms_pkg::CLS_BLANK;
    end else begin
      item.kind = hms_pkg::CLS_OTHER;
    end
  end

endmodule

// File: design/hms_queue.sv
// Small register queue between the classifier and the parser back end.
// Depends on hms_pkg for item_t.
module hms_queue #(
  parameter int Depth = hms_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hms_pkg::item_t wr_data,
  input  logic           pop,
  output hms_pkg::item_t rd_data,
  output logic           not_empty,
  output logic           full
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  hms_pkg::item_t mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == CntW'(Depth));
  assign rd_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: design/hms_back.sv
// Back end: field/total state machine and the result output register.
// Depends on hms_pkg for class codes, widths and item_t.
module hms_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  hms_pkg::item_t                 q_data,
  output logic                           q_pop,
  output logic                           out_valid,
  output logic [hms_pkg::TOTAL_W-1:0]    out_seconds,
  input  logic                           out_stall
);

  localparam logic [1:0] PH_LEAD   = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_TRAIL  = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  localparam int FW = hms_pkg::FIELD_W;
  localparam int TW = hms_pkg::TOTAL_W;

  logic [1:0]    phase_r, phase_nxt;
  logic [1:0]    idx_r, idx_nxt;
  logic [FW-1:0] field_r, field_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [TW-1:0] out_seconds_r, out_seconds_nxt;

  logic          out_free;
  logic [FW+3:0] dig_val;
  logic          dig_ovf;
  logic [TW-1:0] colon_sum;
  logic [TW-1:0] colon_total;
  logic          do_digit, do_colon;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = q_valid && out_free;

  // field*10 + digit, 35 bits so the overflow shows in the top bits
  assign dig_val = ({4'd0, field_r} << 3) + ({4'd0, field_r} << 1)
                   + {{(FW){1'b0}}, q_data.digit};
  assign dig_ovf = (dig_val[FW+3:FW] != 4'd0);

  // (total + field) * 60 as x*64 - x*4, wrapping
  assign colon_sum   = total_r + {1'b0, field_r};
  assign colon_total = (colon_sum << 6) - (colon_sum << 2);

  always_comb begin
    do_digit = 1'b0;
    do_colon = 1'b0;
    phase_nxt = phase_r;
    case (phase_r)
      PH_LEAD: begin
        case (q_data.kind)
          hms_pkg::CLS_BLANK: phase_nxt = phase_r;
          hms_pkg::CLS_DIGIT: do_digit = 1'b1;
          hms_pkg::CLS_COLON: do_colon = 1'b1;
          default:            phase_nxt = PH_DONE;
        endcase
      end
      PH_DIGITS: begin
        case (q_data.kind)
          hms_pkg::CLS_DIGIT: do_digit = 1'b1;
          hms_pkg::CLS_BLANK: phase_nxt = (idx_r >= 2'd2) ? PH_DONE : PH_TRAIL;
          hms_pkg::CLS_COLON: do_colon = 1'b1;
          default:            phase_nxt = PH_DONE;
        endcase
      end
      PH_TRAIL: begin
        case (q_data.kind)
          hms_pkg::CLS_BLANK: phase_nxt = phase_r;
          hms_pkg::CLS_COLON: do_colon = 1'b1;
          default:            phase_nxt = PH_DONE;
        endcase
      end
      default: phase_nxt = phase_r;
    endcase

    idx_nxt   = idx_r;
    field_nxt = field_r;
    total_nxt = total_r;
    if (do_digit) begin
      if (dig_ovf) begin
        field_nxt = '0;
        phase_nxt = PH_DONE;
      end else begin
        field_nxt = dig_val[FW-1:0];
        phase_nxt = PH_DIGITS;
      end
    end
    if (do_colon) begin
      if (idx_r >= 2'd2) begin
        phase_nxt = PH_DONE;
      end else begin
        total_nxt = colon_total;
        field_nxt = '0;
        idx_nxt   = idx_r + 2'd1;
        phase_nxt = PH_LEAD;
      end
    end
  end

  always_comb begin
    out_valid_nxt   = out_valid_r;
    out_seconds_nxt = out_seconds_r;
    if (q_pop && q_data.last) begin
      out_valid_nxt   = 1'b1;
      out_seconds_nxt = total_nxt + {1'b0, field_nxt};
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      idx_r       <= '0;
      field_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        if (q_data.last) begin
          // string ends: back to the start for the next one
          phase_r <= PH_LEAD;
          idx_r   <= '0;
          field_r <= '0;
          total_r <= '0;
        end else begin
          phase_r <= phase_nxt;
          idx_r   <= idx_nxt;
          field_r <= field_nxt;
          total_r <= total_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_seconds_r <= out_seconds_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_seconds = out_seconds_r;

endmodule

// File: design/hms_time_text_to_seconds.sv
// Time text (h:m:s, m:s or s) to seconds parser, one character beat per cycle.
// The last character is written into the queue; when the back end pops it, it is parsed
// straight into the output register behind out_valid, after any beats queued ahead of it.
// Throughput: one character per cycle while no result is held; a held result stops the
// parser, so the queue fills and in_stall rises.
// Reset (synchronous, rst_n low) empties the queue, restarts parsing, drops out_valid.
module hms_time_text_to_seconds #(
  parameter int QueueDepth = hms_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [hms_pkg::CH_W-1:0]          in_ch,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [hms_pkg::TOTAL_W-1:0] out_seconds
);

  hms_pkg::item_t                 f_item;
  hms_pkg::item_t                 q_data;
  logic                           q_push, q_pop, q_valid, q_full;
  logic [hms_pkg::TOTAL_W-1:0]    seconds_u;

  hms_front u_front (
    .ch   (in_ch),
    .last (in_last),
    .item (f_item)
  );

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  hms_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_data   (f_item),
    .pop       (q_pop),
    .rd_data   (q_data),
    .not_empty (q_valid),
    .full      (q_full)
  );

  hms_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_seconds (seconds_u),
    .out_stall   (out_stall)
  );

  assign out_seconds = $signed(seconds_u);

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_data.last) |=> out_valid)
    else $error("last beat popped without a result");

  a_no_phantom_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_valid && !q_push) |=> !q_valid)
    else $error("queue filled without a push");

  a_pop_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !q_pop)
    else $error("parser advanced while result held");

endmodule
